@@ rtl/core/bdsl_pkg.sv @@
// Shared types and constants for the bounded deque with sorted insert.
// Used by bdsl_cell and bounded_deque_sorted_list; no dependencies.
`default_nettype none
package bdsl_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned OUT_DW    = 48;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_SORTED_INS = 3'd2,
    MODE_REMOVE     = 3'd3,
    MODE_POP_FRONT  = 3'd4,
    MODE_POP_BACK   = 3'd5,
    MODE_SEARCH     = 3'd6
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Per-beat commands broadcast to every cell
  typedef struct packed {
    logic ins_en;   // open a gap and write the value
    logic sorted;   // gap position follows the signed compare
    logic del_en;   // close a gap
    logic del_all;  // close the gap at the front
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/bdsl_cell.sv @@
// One list cell: holds one entry, compares it with the beat's value and
// shifts toward either neighbor. Depends on bdsl_pkg.
`default_nettype none
module bdsl_cell (
  input  wire                 clk,
  input  bdsl_pkg::ctl_t      ctl,
  input  bdsl_pkg::val_t      value,
  input  bdsl_pkg::val_t      entry_left,
  input  bdsl_pkg::val_t      entry_right,
  input  wire                 valid,
  input  wire                 force_hit,
  input  wire                 ins_pass_in,
  input  wire                 eq_seen_in,
  output bdsl_pkg::val_t      entry,
  output logic                eq,
  output logic                ins_pass_out,
  output logic                eq_seen_out
);
  import bdsl_pkg::*;

  val_t entry_r;
  val_t entry_nxt;
  logic ge;
  logic hit;
  logic dsel;

  // Compare and pass the prefix flags on to the right neighbor
  always_comb begin
    eq           = valid && (entry_r == value);
    ge           = valid && (entry_r >= value);
    hit          = force_hit || (ctl.sorted && ge) || !valid;
    ins_pass_out = ins_pass_in || hit;
    eq_seen_out  = eq_seen_in || eq;
    dsel         = ctl.del_all || eq_seen_in || eq;
  end

  // Take left on insert past the gap, right on delete at or past it
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en) begin
      if (ins_pass_in) begin
        entry_nxt = entry_left;
      end else if (hit) begin
        entry_nxt = value;
      end
    end else if (ctl.del_en && dsel) begin
      entry_nxt = entry_right;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

@@ rtl/core/bounded_deque_sorted_list.sv @@
// Top level of the bounded deque with sorted insert: a row of bdsl_cell
// instances, the entry count and the result register. Depends on bdsl_pkg.
//
//   channel | dir | tdata                                  | tuser
//   in_     | in  | value[31:0]                            | mode[2:0]
//   out_    | out | position[4:0] popped[36:5] count[41:37] | status[1:0]
//
// One beat per cycle while out_ is not stalled: every cell compares and
// shifts in the same cycle, and the result register loads with that beat.
// Reset clears the entry count and the result valid; entries need no reset.
// A stall on out_ holds the result; in_tready stays high while the result
// register is empty or being drained in the same cycle.
`default_nettype none
module bounded_deque_sorted_list #(
  parameter int unsigned DEPTH = bdsl_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [bdsl_pkg::VAL_W-1:0]   in_tdata,   // value
  input  wire  [bdsl_pkg::MODE_W-1:0]  in_tuser,   // mode
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [bdsl_pkg::OUT_DW-1:0]  out_tdata,  // position, popped_value, entry_count, pad
  output logic [bdsl_pkg::STAT_W-1:0]  out_tuser   // status
);
  import bdsl_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  status_t          status_r, status_nxt;

  logic  accept;
  val_t  value;
  mode_t mode;
  ctl_t  ctl;

  val_t entry   [DEPTH];
  val_t left_e  [DEPTH];
  val_t right_e [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] eq;
  logic [DEPTH:0]   ins_pass;
  logic [DEPTH:0]   eq_seen;
  logic [DEPTH-1:0] force_hit;
  logic [DEPTH-1:0] is_tail;
  logic [DEPTH-1:0] first_eq;

  logic             full, empty, found, tail_hit, head_hit;
  logic [POS_W-1:0] position;
  val_t             tail_val;
  val_t             popped;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign value     = val_t'(in_tdata);
  assign mode      = mode_t'(in_tuser);

  // Cell occupancy and neighbor wiring
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i]   = CNT_W'(i) < count_r;
      left_e[i]  = (i == 0) ? value : entry[(i == 0) ? 0 : i - 1];
      right_e[i] = (i == DEPTH - 1) ? '0 : entry[(i == DEPTH - 1) ? i : i + 1];
      force_hit[i] = (i == 0) && (mode == MODE_PUSH_FRONT);
      is_tail[i] = CNT_W'(i + 1) == count_r;
      first_eq[i] = eq[i] && !eq_seen[i];
    end
  end

  assign ins_pass[0] = 1'b0;
  assign eq_seen[0]  = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bdsl_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .value        (value),
      .entry_left   (left_e[g]),
      .entry_right  (right_e[g]),
      .valid        (valid[g]),
      .force_hit    (force_hit[g]),
      .ins_pass_in  (ins_pass[g]),
      .eq_seen_in   (eq_seen[g]),
      .entry        (entry[g]),
      .eq           (eq[g]),
      .ins_pass_out (ins_pass[g+1]),
      .eq_seen_out  (eq_seen[g+1])
    );
  end

  // Gather tail value, tail match and search position from one-hot lines
  always_comb begin
    tail_val = '0;
    tail_hit = 1'b0;
    position = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | (is_tail[i] ? entry[i] : '0);
      tail_hit = tail_hit | (is_tail[i] && eq[i]);
      position = position | (first_eq[i] ? POS_W'(i + 1) : '0);
    end
  end

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign found    = eq_seen[DEPTH];
  assign head_hit = eq[0];

  // Decode the beat into cell commands, next count and result
  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    popped     = '0;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_SORTED_INS: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.ins_en = accept;
          ctl.sorted = mode == MODE_SORTED_INS;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!head_hit && tail_hit) begin
          count_nxt = count_r - CNT_W'(1);
        end else if (found) begin
          ctl.del_en = accept;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.del_en  = accept;
          ctl.del_all = 1'b1;
          popped      = entry[0];
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped    = tail_val;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_SEARCH: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    out_data_nxt = {6'd0, POS_W'(count_nxt), popped,
                    ((mode == MODE_SEARCH) && !empty) ? position : POS_W'(0)};
  end

  // Hold the result until taken; load on every accepted beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = status_r;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // An insert beat on a full list reports full and keeps the count
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK ||
     mode == MODE_SORTED_INS))
    |=> (status_r == ST_FULL) && (count_r == CNT_W'(DEPTH)))
    else $error("insert on full list not dropped");

  // A pop on an empty list leaves the count at zero and reports empty
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && empty && (mode == MODE_POP_FRONT || mode == MODE_POP_BACK))
    |=> (count_r == '0) && (status_r == ST_EMPTY))
    else $error("pop on empty list changed state");

  // Input stalls only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without pending result");

endmodule
`default_nettype wire
